[hdl/mip_ds_pkg.sv]
package mip_ds_pkg;

	localparam int MAX_SIZE_LOG2 = 12;
	localparam int CHANNEL_BITS = 16;
	localparam int PAIR_BITS = CHANNEL_BITS + 1;
	localparam int QUAD_BITS = CHANNEL_BITS + 2;
	localparam int COUNT_BITS = MAX_SIZE_LOG2;
	localparam int SLOT_BITS = MAX_SIZE_LOG2 - 1;
	localparam int STORE_DEPTH = 1 << SLOT_BITS;
	localparam int LOG2_BITS = 4;

	localparam logic [CHANNEL_BITS-1:0] ALPHA_ONE = CHANNEL_BITS'(256);
	localparam logic [LOG2_BITS-1:0] LEVEL_LOG2_RESET = LOG2_BITS'(12);

	// register index decoded from paddr
	localparam logic REG_LEVEL_SIZE_LOG2 = 1'b0;

	// first field in the highest bits
	typedef struct packed {
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] alpha;
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] red;
	} out_pixel_t;

	typedef struct packed {
		logic [PAIR_BITS-1:0] blue;
		logic [PAIR_BITS-1:0] green;
		logic [PAIR_BITS-1:0] red;
	} pair_t;

	typedef struct packed {
		out_pixel_t pix;
		logic       done;
	} result_t;

endpackage

[hdl/mip_downsample_2x2_box_unit.sv]
// 2x2 box-filter mip downsampler. Pixels of a square 2^L x 2^L level (L from the
// level_size_log2 register, clamped to 1..12) enter in raster order at one item per
// clock, red/green/blue as unsigned Q8.8 in s_tdata. Each output item is the
// truncated average of one 2x2 block, with alpha fixed at 1.0 (256); one item leaves
// on every odd column of every odd row, and m_tlast marks the final item of the
// level. The horizontal pair sums of each even row sit in a 2048 x 51 bit line
// store with one write and one registered read port: the even pixel of an odd row
// issues the read, the odd pixel consumes it, so the sustained rate is one input
// item per clock while s_tready is high, and m_tvalid is registered. A two-entry
// output register (main plus skid) keeps input flowing while a result waits. After the
// last pixel the level restarts at the same size; any write to level_size_log2
// restarts the level at row 0. The line store needs no clearing after reset, since
// every odd row reads only entries written by the even row above it.
module mip_downsample_2x2_box_unit
	import mip_ds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input pixels
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // red_in, green_in, blue_in
	// output pixels
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic        m_tlast    // level_done
);

	logic [LOG2_BITS-1:0]  level_log2_q;
	logic [LOG2_BITS-1:0]  eff_log2;
	logic [COUNT_BITS-1:0] last_w;
	logic [COUNT_BITS-1:0] col_q;
	logic [COUNT_BITS-1:0] row_q;
	pixel_t                pending_q;
	pixel_t                px;
	pair_t                 pair;
	pair_t                 rd_q;
	logic [SLOT_BITS-1:0]  slot;
	logic                  accept;
	logic                  cfg_wr;
	logic                  produce;
	logic                  done_w;
	logic [QUAD_BITS-1:0]  sum_r, sum_g, sum_b;
	result_t               result;
	result_t               out_q, skid_q;
	logic                  out_v_q, skid_v_q;

	// line store of pair sums, indexed by column / 2
	pair_t                 store [STORE_DEPTH];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LEVEL_SIZE_LOG2);
	assign prdata = (paddr[2] == REG_LEVEL_SIZE_LOG2) ? 32'(level_log2_q) : 32'd0;

	// clamp level size to 1..max
	always_comb begin
		eff_log2 = level_log2_q;
		if (level_log2_q < LOG2_BITS'(1))
			eff_log2 = LOG2_BITS'(1);
		if (level_log2_q > LOG2_BITS'(MAX_SIZE_LOG2))
			eff_log2 = LOG2_BITS'(MAX_SIZE_LOG2);
	end

	assign last_w = COUNT_BITS'(((COUNT_BITS+1)'(1) << eff_log2) - (COUNT_BITS+1)'(1));

	assign px       = pixel_t'(s_tdata);
	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;
	assign slot     = col_q[COUNT_BITS-1:1];

	assign pair.red   = PAIR_BITS'(pending_q.red) + PAIR_BITS'(px.red);
	assign pair.green = PAIR_BITS'(pending_q.green) + PAIR_BITS'(px.green);
	assign pair.blue  = PAIR_BITS'(pending_q.blue) + PAIR_BITS'(px.blue);

	// upper pair from the store plus lower pair, truncated by four
	assign sum_r = QUAD_BITS'(rd_q.red) + QUAD_BITS'(pair.red);
	assign sum_g = QUAD_BITS'(rd_q.green) + QUAD_BITS'(pair.green);
	assign sum_b = QUAD_BITS'(rd_q.blue) + QUAD_BITS'(pair.blue);

	assign produce = accept && col_q[0] && row_q[0];
	assign done_w  = (col_q == last_w) && (row_q == last_w);

	always_comb begin
		result.pix.red   = sum_r[QUAD_BITS-1:2];
		result.pix.green = sum_g[QUAD_BITS-1:2];
		result.pix.blue  = sum_b[QUAD_BITS-1:2];
		result.pix.alpha = ALPHA_ONE;
		result.done      = done_w;
	end

	// config register and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_log2_q <= LEVEL_LOG2_RESET;
			col_q        <= '0;
			row_q        <= '0;
		end else if (cfg_wr) begin
			level_log2_q <= pwdata[LOG2_BITS-1:0];
			col_q        <= '0;
			row_q        <= '0;
		end else if (accept) begin
			if (col_q >= last_w) begin
				col_q <= '0;
				row_q <= (row_q >= last_w) ? '0 : row_q + COUNT_BITS'(1);
			end else begin
				col_q <= col_q + COUNT_BITS'(1);
			end
		end
	end

	// even-column pixel waits for its partner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept && !col_q[0]) begin
			pending_q <= px;
		end
	end

	// line store: write on odd column of even row, read on even column of odd row.
	// reads and writes never hit the same row, so no forwarding path is needed
	always_ff @(posedge clk) begin
		if (accept && col_q[0] && !row_q[0])
			store[slot] <= pair;
		if (accept && !col_q[0] && row_q[0])
			rd_q <= store[slot];
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= produce;
			end
		end else if (produce) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_v_q) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (produce)
				out_q <= result;
		end else if (produce) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.pix;
	assign m_tlast  = out_q.done;

	// skid entry only fills behind a held output item
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without output item");

	a_pos_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr |=> (col_q <= last_w) && (row_q <= last_w))
		else $error("raster position beyond level size");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		produce && out_v_q && !m_tready |=> skid_v_q)
		else $error("result lost while output stalled");

	a_alpha_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:48] == ALPHA_ONE))
		else $error("alpha not one");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import mip_ds_pkg::*;

	// apb byte addresses: the level register, and one address with no register behind it
	localparam logic [2:0] LEVEL_ADDR = 3'd0;
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	// cycles with no accepted item before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// random items to feed after the directed part
	localparam int RANDOM_ITEMS = 260;
	// wide level: two full rows reach the top store slot of that size
	localparam int WIDE_LOG2 = 7;
	localparam int WIDE_ROW = 1 << WIDE_LOG2;

	typedef enum int {
		FLOW_FREE,
		FLOW_SRC_GAPS,
		FLOW_SINK_STALLS,
		FLOW_BOTH
	} flow_t;

	// predicts the averaged 2x2 blocks of the stream and holds them until they leave the dut
	class quad_average_tracker;
		logic [LOG2_BITS-1:0] size_code;
		logic [COUNT_BITS-1:0] col;
		logic [COUNT_BITS-1:0] row;
		pixel_t held;
		pair_t row_pairs [STORE_DEPTH];
		result_t queued [$];
		int errors;

		function new();
			size_code = LEVEL_LOG2_RESET;
			col = '0;
			row = '0;
			held = '0;
			errors = 0;
		endfunction

		function void restart(logic [LOG2_BITS-1:0] code);
			size_code = code;
			col = '0;
			row = '0;
		endfunction

		function int pending();
			return queued.size();
		endfunction

		function logic [CHANNEL_BITS-1:0] quarter(logic [PAIR_BITS-1:0] upper,
				logic [PAIR_BITS-1:0] lower);
			logic [QUAD_BITS-1:0] sum;
			sum = QUAD_BITS'(upper) + QUAD_BITS'(lower);
			return sum[QUAD_BITS-1:2];
		endfunction

		function void take_pixel(pixel_t px);
			int side;
			logic [COUNT_BITS-1:0] edge_pos;
			logic [SLOT_BITS-1:0] slot;
			pair_t pair;
			result_t res;
			// out of range sizes clamp to 1..max
			if (size_code < 1)
				side = 1;
			else if (size_code > MAX_SIZE_LOG2)
				side = MAX_SIZE_LOG2;
			else
				side = int'(size_code);
			edge_pos = COUNT_BITS'((1 << side) - 1);
			slot = col[COUNT_BITS-1:1];
			if (!col[0]) begin
				held = px;
			end else begin
				pair.red = PAIR_BITS'(held.red) + PAIR_BITS'(px.red);
				pair.green = PAIR_BITS'(held.green) + PAIR_BITS'(px.green);
				pair.blue = PAIR_BITS'(held.blue) + PAIR_BITS'(px.blue);
				if (!row[0]) begin
					row_pairs[slot] = pair;
				end else begin
					res.pix.red = quarter(row_pairs[slot].red, pair.red);
					res.pix.green = quarter(row_pairs[slot].green, pair.green);
					res.pix.blue = quarter(row_pairs[slot].blue, pair.blue);
					res.pix.alpha = ALPHA_ONE;
					res.done = (row == edge_pos) && (col == edge_pos);
					queued.push_back(res);
				end
			end
			if (col >= edge_pos) begin
				col = '0;
				row = (row >= edge_pos) ? '0 : row + COUNT_BITS'(1);
			end else begin
				col = col + COUNT_BITS'(1);
			end
		endfunction

		function void compare_field(string name, logic [CHANNEL_BITS-1:0] want,
				logic [CHANNEL_BITS-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void match_output(out_pixel_t got, logic got_done);
			result_t want;
			if (queued.size() == 0) begin
				errors++;
				$display("%0t: output item with none expected, actual %h last %b",
					$time, got, got_done);
				return;
			end
			want = queued.pop_front();
			compare_field("red", want.pix.red, got.red);
			compare_field("green", want.pix.green, got.green);
			compare_field("blue", want.pix.blue, got.blue);
			compare_field("alpha", want.pix.alpha, got.alpha);
			compare_field("level_done", CHANNEL_BITS'(want.done), CHANNEL_BITS'(got_done));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [47:0] s_tdata;   // red_in, green_in, blue_in
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;   // red_out, green_out, blue_out, alpha_out
	logic m_tlast;          // level_done

	quad_average_tracker tracker;
	// percent chance per cycle that the source holds back / the sink stalls
	int src_idle = 0;
	int sink_stall = 0;
	int quiet_cycles = 0;

	mip_downsample_2x2_box_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check every accepted item, then pick the next tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_output(out_pixel_t'(m_tdata), m_tlast);
		m_tready <= ($urandom_range(99) >= sink_stall);
	end

	// hang detection: any handshake or bus access counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("mip_downsample_2x2_box_unit verification failed");
			$finish;
		end
	end

	function automatic pixel_t rgb(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
			logic [CHANNEL_BITS-1:0] b);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		return px;
	endfunction

	// random channel with extra weight on the extremes
	function automatic logic [CHANNEL_BITS-1:0] random_channel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return CHANNEL_BITS'($urandom());
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		return rgb(random_channel(), random_channel(), random_channel());
	endfunction

	task automatic set_traffic(flow_t flow);
		case (flow)
			FLOW_FREE: begin
				src_idle = 0;
				sink_stall = 0;
			end
			FLOW_SRC_GAPS: begin
				src_idle = 86;
				sink_stall = 0;
			end
			FLOW_SINK_STALLS: begin
				src_idle = 0;
				sink_stall = 86;
			end
			default: begin
				src_idle = 29;
				sink_stall = 29;
			end
		endcase
	endtask

	// offer one item, with a random gap first, and return at the edge that takes it
	task automatic push_pixel(pixel_t px);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			s_tdata <= random_pixel();
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		tracker.take_pixel(px);
	endtask

	task automatic bus_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic bus_read(logic [2:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_level_reg(logic [LOG2_BITS-1:0] code);
		logic [31:0] readback;
		bus_read(LEVEL_ADDR, readback);
		if (readback !== 32'(code)) begin
			tracker.errors++;
			$display("%0t: level_size_log2 readback mismatch, expected %h, actual %h",
				$time, 32'(code), readback);
		end
	endtask

	// stop feeding, let every expected item leave, then cover the pipeline latency
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// any write restarts the level, so the predictor restarts with it
	task automatic set_level(logic [LOG2_BITS-1:0] code);
		logic [31:0] data;
		drain();
		data = $urandom();
		data[LOG2_BITS-1:0] = code;
		bus_write(LEVEL_ADDR, data);
		tracker.restart(code);
		check_level_reg(code);
	endtask

	initial begin
		int fed;
		int phase;
		int count;
		int pick;
		logic [LOG2_BITS-1:0] code;

		tracker = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size is the largest, so a short run must give no output
		set_traffic(FLOW_FREE);
		check_level_reg(LEVEL_LOG2_RESET);
		repeat (4) push_pixel(random_pixel());

		// 2x2 levels back to back: full scale, zero, then truncation of the quarter sum
		set_level(4'd1);
		repeat (4) push_pixel(rgb('1, '1, '1));
		repeat (4) push_pixel(rgb('0, '0, '0));
		push_pixel(rgb(16'd1, 16'hffff, 16'd3));
		push_pixel(rgb(16'd2, 16'hffff, 16'd0));
		push_pixel(rgb(16'd3, 16'hffff, 16'd0));
		push_pixel(rgb(16'd0, 16'hfffe, 16'd0));

		// a write to an address with no register must leave the level running
		push_pixel(rgb(16'hffff, 16'h0000, 16'hffff));
		push_pixel(rgb(16'h0000, 16'hffff, 16'h0000));
		drain();
		bus_write(SPARE_ADDR, $urandom());
		push_pixel(rgb(16'h0000, 16'hffff, 16'h0000));
		push_pixel(rgb(16'hffff, 16'h0000, 16'hffff));

		// size zero acts as one, sizes above the maximum act as the maximum
		set_level(4'd0);
		repeat (4) push_pixel(random_pixel());
		set_level(4'd15);
		repeat (4) push_pixel(random_pixel());

		// wide level: two full rows plus a little, touching its last store slot
		set_traffic(FLOW_BOTH);
		set_level(LOG2_BITS'(WIDE_LOG2));
		repeat (2 * WIDE_ROW + 4) push_pixel(random_pixel());

		// random phases: mostly small levels that wrap, cut off mid-level by the next write
		fed = 0;
		phase = 0;
		while (fed < RANDOM_ITEMS) begin
			pick = $urandom_range(19);
			if (pick < 15)
				code = LOG2_BITS'($urandom_range(1, 4));
			else if (pick == 15)
				code = '0;
			else if (pick == 16)
				code = LOG2_BITS'($urandom_range(5, 6));
			else
				code = LOG2_BITS'($urandom_range(12, 15));
			if (code >= 6)
				count = $urandom_range(4, 12);
			else
				count = $urandom_range(20, 90);
			set_traffic(flow_t'(phase % 4));
			set_level(code);
			repeat (count) push_pixel(random_pixel());
			fed += count;
			phase++;
		end

		drain();
		repeat (4) @(posedge clk);
		if (tracker.errors == 0)
			$display("mip_downsample_2x2_box_unit verification clean");
		else
			$display("mip_downsample_2x2_box_unit verification failed");
		$finish;
	end

endmodule
